// ===== src/outstanding_task_tracker_assert.svh =====
// Assertion macros used by the tracker datapath (ott_dp).
`ifndef OUTSTANDING_TASK_TRACKER_ASSERT_SVH
`define OUTSTANDING_TASK_TRACKER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define OTT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("%m: check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define OTT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("%m: check failed");

`endif

// ===== src/ott_pkg.sv =====
// Types and constants of the outstanding task tracker.
`default_nettype none
package ott_pkg;

	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_REMOVE = 2'd1;
	localparam logic [1:0] FUNC_LOOKUP = 2'd2;
	localparam logic [1:0] FUNC_CLEAR  = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_STREAM = 2'd1;
	localparam logic [1:0] ST_POOL_FULL = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	localparam logic [15:0] NO_MODEL = 16'hFFFF;

	typedef struct packed {
		logic [1:0]  func;
		logic [2:0]  proc_id;
		logic [15:0] task_tag;
		logic [15:0] stream_num;
		logic        is_model_task;
		logic [15:0] model_in;
		logic [7:0]  mode_in;
	} in_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  mode_out;
		logic [15:0] model_out;
		logic        model_report;
	} out_rsp_t;

	// Per-slot record kept in RAM.
	typedef struct packed {
		logic [15:0] model;
		logic [7:0]  mode;
	} slot_rec_t;

	typedef struct packed {
		logic capture;
		logic commit;
		logic respond;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_read;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== src/ott_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ott_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== src/ott_ctrl.sv =====
// Controller state machine of the tracker.
`default_nettype none
module ott_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	output ott_pkg::ctrl_cmd_t     cmd,
	input  wire ott_pkg::dp_stat_t stat
);
	import ott_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_PICK = 2'd1;
	localparam logic [1:0] S_READ = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_PICK;
			end
			S_PICK: begin
				state_d = stat.need_read ? S_READ : S_IDLE;
			end
			S_READ: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign cmd.capture = start && (state_q == S_IDLE);
	assign cmd.commit  = (state_q == S_PICK);
	assign cmd.respond = (state_q == S_READ);
endmodule
`default_nettype wire

// ===== src/ott_dp.sv =====
// Datapath: tag match array, age matrix, slot record RAM and result register.
`default_nettype none
`include "outstanding_task_tracker_assert.svh"
module ott_dp #(
	parameter int POOL_ENTRIES = 64,
	parameter int PROC_COUNT   = 8,
	parameter int STREAM_LIMIT = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ott_pkg::ctrl_cmd_t cmd,
	output ott_pkg::dp_stat_t       stat,
	input  wire ott_pkg::in_req_t   req,
	output logic                    done,
	output ott_pkg::out_rsp_t       rsp
);
	import ott_pkg::*;

	localparam int N  = POOL_ENTRIES;
	localparam int IW = $clog2(POOL_ENTRIES);
	localparam logic [16:0] SLIM = 17'(STREAM_LIMIT);
	localparam logic [6:0]  PLIM = 7'(PROC_COUNT);

	// Slot state
	logic [N-1:0]  used_q;
	logic [2:0]    owner_q [N];
	logic [15:0]   task_q  [N];
	// older_q[i][j] set: slot j went in before slot i
	logic [N-1:0]  older_q [N];

	in_req_t       req_q;
	logic [N-1:0]  hit_d, own_d;
	logic [N-1:0]  hit_s1, own_s1;

	logic [N-1:0]  pick_oh, free_vec, free_oh;
	logic [IW-1:0] pick_idx, free_idx;
	logic          hit_any, pool_full, stream_ok, proc_ok;
	logic [1:0]    st_d;
	logic          ins_ok, rem_ok;
	logic [N-1:0]  ins_oh, kill_vec;

	slot_rec_t     wr_rec, rd_rec;
	logic          done_q;
	out_rsp_t      rsp_q;
	logic [IW:0]   used_cnt;

	// Match against the incoming request, registered at capture.
	always_comb begin
		for (int i = 0; i < N; i++) begin
			own_d[i] = used_q[i] && (owner_q[i] == req.proc_id);
			hit_d[i] = own_d[i] && (task_q[i] == req.task_tag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1 <= '0;
			own_s1 <= '0;
		end else if (cmd.capture) begin
			hit_s1 <= hit_d;
			own_s1 <= own_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
	end

	// Oldest hit: no other hit is older than it.
	always_comb begin
		pick_idx = '0;
		for (int i = 0; i < N; i++) begin
			pick_oh[i] = hit_s1[i] && !(|(older_q[i] & hit_s1));
			if (pick_oh[i]) pick_idx = pick_idx | IW'(i);
		end
	end

	// Lowest free slot.
	assign free_vec  = ~used_q;
	assign free_oh   = free_vec & (~free_vec + N'(1));
	assign pool_full = ~|free_vec;
	assign hit_any   = |hit_s1;

	always_comb begin
		free_idx = '0;
		for (int i = 0; i < N; i++) begin
			if (free_oh[i]) free_idx = free_idx | IW'(i);
		end
	end

	assign stream_ok = {1'b0, req_q.stream_num} < SLIM;
	assign proc_ok   = {4'b0, req_q.proc_id} < PLIM;

	always_comb begin
		case (req_q.func)
			FUNC_INSERT: begin
				if (!stream_ok)              st_d = ST_BAD_STREAM;
				else if (!proc_ok || pool_full) st_d = ST_POOL_FULL;
				else                         st_d = ST_OK;
			end
			FUNC_REMOVE: begin
				if (!stream_ok)    st_d = ST_BAD_STREAM;
				else if (!hit_any) st_d = ST_NOT_FOUND;
				else               st_d = ST_OK;
			end
			FUNC_LOOKUP: begin
				st_d = hit_any ? ST_OK : ST_NOT_FOUND;
			end
			default: begin
				st_d = ST_OK;
			end
		endcase
	end

	assign ins_ok = (req_q.func == FUNC_INSERT) && (st_d == ST_OK);
	assign rem_ok = (req_q.func == FUNC_REMOVE) && (st_d == ST_OK);
	assign ins_oh = ins_ok ? free_oh : '0;

	always_comb begin
		if (rem_ok)                          kill_vec = pick_oh;
		else if (req_q.func == FUNC_CLEAR)   kill_vec = own_s1;
		else                                 kill_vec = '0;
	end

	assign stat.need_read = (st_d == ST_OK) &&
		(req_q.func inside {FUNC_REMOVE, FUNC_LOOKUP});

	// Slot state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			for (int i = 0; i < N; i++) older_q[i] <= '0;
		end else if (cmd.commit) begin
			used_q <= (used_q | ins_oh) & ~kill_vec;
			for (int i = 0; i < N; i++) begin
				if (ins_oh[i])       older_q[i] <= used_q;
				else if (kill_vec[i]) older_q[i] <= '0;
				else                 older_q[i] <= older_q[i] & ~(ins_oh | kill_vec);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < N; i++) begin
			if (cmd.commit && ins_oh[i]) begin
				owner_q[i] <= req_q.proc_id;
				task_q[i]  <= req_q.task_tag;
			end
		end
	end

	assign wr_rec.model = req_q.is_model_task ? req_q.model_in : NO_MODEL;
	assign wr_rec.mode  = req_q.mode_in;

	ott_ram #(
		.WIDTH($bits(slot_rec_t)),
		.DEPTH(POOL_ENTRIES)
	) u_rec_ram (
		.clk  (clk),
		.we   (cmd.commit && ins_ok),
		.waddr(free_idx),
		.wdata(wr_rec),
		.re   (cmd.commit),
		.raddr(pick_idx),
		.rdata(rd_rec)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (cmd.commit && !stat.need_read) || cmd.respond;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && !stat.need_read) begin
			rsp_q.status       <= st_d;
			rsp_q.mode_out     <= '0;
			rsp_q.model_out    <= NO_MODEL;
			rsp_q.model_report <= 1'b0;
		end else if (cmd.respond) begin
			rsp_q.status <= ST_OK;
			if (req_q.func == FUNC_REMOVE) begin
				rsp_q.mode_out     <= rd_rec.mode;
				rsp_q.model_out    <= NO_MODEL;
				rsp_q.model_report <= (rd_rec.model != NO_MODEL);
			end else begin
				rsp_q.mode_out     <= '0;
				rsp_q.model_out    <= rd_rec.model;
				rsp_q.model_report <= 1'b0;
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// occupancy, for the checks below
	assign used_cnt = (IW+1)'($countones(used_q));

	`OTT_ASSERT_NOW(a_pick_onehot, cmd.commit && hit_any, $onehot(pick_oh))
	`OTT_ASSERT_NEXT(a_insert_grows, cmd.commit && ins_ok, used_cnt == $past(used_cnt) + 1'b1)
	`OTT_ASSERT_NEXT(a_remove_shrinks, cmd.commit && rem_ok, used_cnt + 1'b1 == $past(used_cnt))
	`OTT_ASSERT_NEXT(a_done_pulse, done_q, !done_q)
endmodule
`default_nettype wire

// ===== src/outstanding_task_tracker.sv =====
// Top level of the outstanding task tracker: controller plus datapath.
// Result strobe: registered from the commit state for insert, clear and any
//   error; from the respond state for a remove or lookup that hits (RAM read).
// A new request is accepted only while idle, after the commit and any respond state.
// A new request is taken in the same cycle its predecessor's result is shown.
// The receiver cannot stall; done is a one-cycle strobe.
// Reset (arst_n low, async): pool all free, age matrix cleared, controller idle.
`default_nettype none
module outstanding_task_tracker #(
	parameter int POOL_ENTRIES = 64,
	parameter int PROC_COUNT   = 8,
	parameter int STREAM_LIMIT = 1024
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire ott_pkg::in_req_t req,
	output logic                  done,
	output ott_pkg::out_rsp_t     rsp
);
	import ott_pkg::*;

	// Controller/datapath handshake: capture latches the request and the
	// registered tag match; commit does the age pick, free-slot pick and the
	// state update; respond forms the result from the RAM read data.
	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	ott_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.stat  (stat)
	);

	// Datapath holds the slot match array (owner, tag), the age matrix that
	// orders slots by insertion, and the RAM with model id and work mode.
	ott_dp #(
		.POOL_ENTRIES(POOL_ENTRIES),
		.PROC_COUNT  (PROC_COUNT),
		.STREAM_LIMIT(STREAM_LIMIT)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.stat  (stat),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);
endmodule
`default_nettype wire
